// ----- rtl/core/awbd_pkg.sv -----
// Package for the alpha weighted box downscaler: sizes, widths, codes, types.
// Used by the channel interfaces, the divider, the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package awbd_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;

   localparam int PIX_W = 8;
   localparam int COL_W = $clog2(MAX_WIDTH);     // output or source column index
   localparam int ROW_W = $clog2(MAX_HEIGHT);    // output or source row index
   localparam int SW_W  = 12;                    // width register
   localparam int SH_W  = 13;                    // height register
   localparam int CP_W  = 2 * COL_W + 2;         // column products index*size
   localparam int RP_W  = 2 * ROW_W + 2;         // row products
   localparam int SUM_W = 32;
   localparam int CNT_W = 24;
   localparam int NUM_W = SUM_W + PIX_W;         // sum*255

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 2'd3;

   localparam logic [SW_W-1:0] SRC_WIDTH_RST  = SW_W'(2048);
   localparam logic [SH_W-1:0] SRC_HEIGHT_RST = SH_W'(4096);
   localparam logic [SW_W-1:0] DST_WIDTH_RST  = SW_W'(1024);
   localparam logic [SH_W-1:0] DST_HEIGHT_RST = SH_W'(2048);

   localparam logic [SW_W-1:0] WIDTH_TOP  = SW_W'(MAX_WIDTH);
   localparam logic [SH_W-1:0] HEIGHT_TOP = SH_W'(MAX_HEIGHT);

   // which quotient the shared divider is working on
   localparam logic [1:0] SEL_RED   = 2'd0;
   localparam logic [1:0] SEL_GREEN = 2'd1;
   localparam logic [1:0] SEL_BLUE  = 2'd2;
   localparam logic [1:0] SEL_ALPHA = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   // one accumulator entry, per output column
   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
      logic [SUM_W-1:0] alpha;
      logic [CNT_W-1:0] count;
   } acc_type;

   localparam int ACC_W = $bits(acc_type);

   // floor(c*a/255), exact for any 16-bit product
   function automatic logic [PIX_W-1:0] premul(input logic [PIX_W-1:0] c,
                                               input logic [PIX_W-1:0] a);
      logic [2*PIX_W-1:0] p;
      logic [2*PIX_W:0]   t;
      p = c * a;
      t = {1'b0, p} + {9'b0, p[2*PIX_W-1:PIX_W]} + 17'd1;
      return t[2*PIX_W-1:PIX_W];
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/awbd_chan_if.sv -----
// Valid/ready channels of the downscaler: source pixels in, output pixels out.
// Depends on awbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface awbd_req_if import awbd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;
   logic [PIX_W-1:0] alpha;
   modport source (output valid, red, green, blue, alpha, input ready);
   modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface awbd_rsp_if import awbd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] out_red;
   logic [PIX_W-1:0] out_green;
   logic [PIX_W-1:0] out_blue;
   logic [PIX_W-1:0] out_alpha;
   logic             frame_end;
   modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_end,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_alpha, frame_end,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/core/awbd_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module awbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- rtl/core/awbd_div.sv -----
// Restoring divider for quotients known to be below 256: one quotient bit a cycle.
// Depends on awbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module awbd_div import awbd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [SUM_W-1:0] denom,
   output logic                  done,
   output logic      [PIX_W-1:0] quot
);
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] dsh_ff, dsh_in;
   logic [PIX_W-1:0] q_ff, q_in;
   logic [2:0]       step_ff, step_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             ge;

   assign ge = rem_ff >= dsh_ff;

   // next state: load on start, then one trial subtract per cycle
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = numer;
         dsh_in  = {1'b0, denom, 7'b0};
         q_in    = '0;
         step_in = 3'd7;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         q_in   = {q_ff[PIX_W-2:0], ge};
         dsh_in = dsh_ff >> 1;
         if (step_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

// ----- rtl/core/alpha_weighted_box_downscale.sv -----
// Alpha weighted box downscaler, top level. Depends on awbd_pkg, the channel
// interfaces, awbd_ram and awbd_div.
`timescale 1ns / 1ps
`default_nettype none
// Shrinks an RGBA image arriving in raster order by area averaging. Colours are
// weighted by alpha; the output alpha is the plain block average. A pixel that
// does not close a block passes through an accumulator read, then a write back. A
// pixel that closes a block also loads the output register; when the block is not
// fully transparent, the shared divider first works out the three colour quotients
// and the alpha quotient in turn, one bit a cycle. While the output register still
// holds an item that has not been taken, the closing pixel waits there. Column
// accumulators live in one RAM of MAX_WIDTH entries, written by the first pixel of
// each block, so no clearing is needed. Any register write restarts the frame;
// write only while idle. Sizes of zero count as one, and a target larger than the
// source counts as the source.
module alpha_weighted_box_downscale import awbd_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   awbd_req_if.sink                   req_chan,
   awbd_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   // configuration
   logic [SW_W-1:0] src_w_ff, dst_w_ff;
   logic [SH_W-1:0] src_h_ff, dst_h_ff;
   logic [SW_W-1:0] sw, tw;
   logic [SH_W-1:0] sh, th;

   // position counters and band products
   logic [COL_W-1:0] sc_ff, sc_in, ox_ff, ox_in;
   logic [ROW_W-1:0] sr_ff, sr_in, oy_ff, oy_in;
   logic [CP_W-1:0]  cs_ff, cs_in, ca_ff, ca_in;
   logic [RP_W-1:0]  rs_ff, rs_in, ra_ff, ra_in;

   state_type        state_ff, state_in;
   logic [PIX_W-1:0] pr_ff, pg_ff, pb_ff, pa_ff;
   logic [COL_W-1:0] addr_ff;
   logic             first_ff, emit_ff, fend_ff;
   acc_type          acc_ff, acc_new, rd_acc;
   logic [1:0]       sel_ff, sel_in;
   logic             kick_ff, kick_in;
   logic [PIX_W-1:0] qr_ff, qg_ff, qb_ff, qa_ff;

   logic             rsp_valid_ff;
   logic [PIX_W-1:0] o_r_ff, o_g_ff, o_b_ff, o_a_ff;
   logic             o_fe_ff;

   logic accept, cfg_hit, col_start, col_end, row_start, row_end, last_col, last_row;
   logic wr_en, div_done, out_free;
   logic [ACC_W-1:0] rd_data;
   logic [NUM_W-1:0] div_num;
   logic [SUM_W-1:0] div_den, sel_sum;
   logic [PIX_W-1:0] div_q;

   // effective sizes
   always_comb begin
      sw = (src_w_ff == '0) ? SW_W'(1) : ((src_w_ff > WIDTH_TOP) ? WIDTH_TOP : src_w_ff);
      sh = (src_h_ff == '0) ? SH_W'(1) : ((src_h_ff > HEIGHT_TOP) ? HEIGHT_TOP : src_h_ff);
      tw = (dst_w_ff == '0) ? SW_W'(1) : ((dst_w_ff > sw) ? sw : dst_w_ff);
      th = (dst_h_ff == '0) ? SH_W'(1) : ((dst_h_ff > sh) ? sh : dst_h_ff);
   end

   assign cfg_hit = csr_we;
   assign accept  = req_chan.valid & req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // band tests: cs = sc*tw, ca = ox*sw (rows alike)
   assign col_start = ca_ff >= cs_ff;
   assign col_end   = (ca_ff + CP_W'(sw)) < (cs_ff + CP_W'({tw, 1'b0}));
   assign row_start = ra_ff >= rs_ff;
   assign row_end   = (ra_ff + RP_W'(sh)) < (rs_ff + RP_W'({th, 1'b0}));
   assign last_col  = (SW_W'(sc_ff) + SW_W'(1)) == sw;
   assign last_row  = (SH_W'(sr_ff) + SH_W'(1)) == sh;

   // position advance per accepted item; any register write clears the positions
   always_comb begin
      sc_in = sc_ff; ox_in = ox_ff; sr_in = sr_ff; oy_in = oy_ff;
      cs_in = cs_ff; ca_in = ca_ff; rs_in = rs_ff; ra_in = ra_ff;
      if (cfg_hit) begin
         sc_in = '0; ox_in = '0; sr_in = '0; oy_in = '0;
         cs_in = '0; ca_in = '0; rs_in = '0; ra_in = '0;
      end else if (accept) begin
         if (last_col) begin
            sc_in = '0; cs_in = '0; ox_in = '0; ca_in = '0;
            if (last_row) begin
               sr_in = '0; rs_in = '0; oy_in = '0; ra_in = '0;
            end else begin
               sr_in = sr_ff + ROW_W'(1);
               rs_in = rs_ff + RP_W'(th);
               if (row_end) begin
                  oy_in = oy_ff + ROW_W'(1);
                  ra_in = ra_ff + RP_W'(sh);
               end
            end
         end else begin
            sc_in = sc_ff + COL_W'(1);
            cs_in = cs_ff + CP_W'(tw);
            if (col_end) begin
               ox_in = ox_ff + COL_W'(1);
               ca_in = ca_ff + CP_W'(sw);
            end
         end
      end
   end

   // accumulator update
   assign rd_acc = acc_type'(rd_data);
   always_comb begin
      logic [PIX_W-1:0] mr, mg, mb;
      mr = premul(pr_ff, pa_ff);
      mg = premul(pg_ff, pa_ff);
      mb = premul(pb_ff, pa_ff);
      if (first_ff) begin
         acc_new.red   = SUM_W'(mr);
         acc_new.green = SUM_W'(mg);
         acc_new.blue  = SUM_W'(mb);
         acc_new.alpha = SUM_W'(pa_ff);
         acc_new.count = CNT_W'(1);
      end else begin
         acc_new.red   = rd_acc.red + SUM_W'(mr);
         acc_new.green = rd_acc.green + SUM_W'(mg);
         acc_new.blue  = rd_acc.blue + SUM_W'(mb);
         acc_new.alpha = rd_acc.alpha + SUM_W'(pa_ff);
         acc_new.count = rd_acc.count + CNT_W'(1);
      end
   end

   assign wr_en = (state_ff == ST_READ);

   awbd_ram #(.WIDTH(ACC_W), .DEPTH(MAX_WIDTH)) u_acc_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (acc_new),
      .rd_addr (ox_ff),
      .rd_data (rd_data)
   );

   // divider operands
   always_comb begin
      case (sel_ff)
         SEL_RED:   sel_sum = acc_ff.red;
         SEL_GREEN: sel_sum = acc_ff.green;
         SEL_BLUE:  sel_sum = acc_ff.blue;
         default:   sel_sum = acc_ff.alpha;
      endcase
      if (sel_ff == SEL_ALPHA) begin
         div_num = NUM_W'(acc_ff.alpha);
         div_den = SUM_W'(acc_ff.count);
      end else begin
         div_num = {sel_sum, 8'b0} - NUM_W'(sel_sum);
         div_den = acc_ff.alpha;
      end
   end

   awbd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (kick_ff),
      .numer (div_num),
      .denom (div_den),
      .done  (div_done),
      .quot  (div_q)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // sequencer
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      kick_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            sel_in = SEL_RED;
            if (!emit_ff) begin
               state_in = ST_IDLE;
            end else if (acc_new.alpha == '0 || acc_new.count == '0) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_DIV;
               kick_in  = 1'b1;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (sel_ff == SEL_ALPHA) begin
                  state_in = ST_OUT;
               end else begin
                  sel_in  = sel_ff + 2'd1;
                  kick_in = 1'b1;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kick_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         src_w_ff     <= SRC_WIDTH_RST;
         src_h_ff     <= SRC_HEIGHT_RST;
         dst_w_ff     <= DST_WIDTH_RST;
         dst_h_ff     <= DST_HEIGHT_RST;
         sc_ff <= '0; ox_ff <= '0; sr_ff <= '0; oy_ff <= '0;
         cs_ff <= '0; ca_ff <= '0; rs_ff <= '0; ra_ff <= '0;
      end else begin
         state_ff <= state_in;
         kick_ff  <= kick_in;
         sc_ff <= sc_in; ox_ff <= ox_in; sr_ff <= sr_in; oy_ff <= oy_in;
         cs_ff <= cs_in; ca_ff <= ca_in; rs_ff <= rs_in; ra_ff <= ra_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SRC_WIDTH:  src_w_ff <= csr_wdata[SW_W-1:0];
               CSR_SRC_HEIGHT: src_h_ff <= csr_wdata[SH_W-1:0];
               CSR_DST_WIDTH:  dst_w_ff <= csr_wdata[SW_W-1:0];
               CSR_DST_HEIGHT: dst_h_ff <= csr_wdata[SH_W-1:0];
               default: ;
            endcase
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
      if (accept) begin
         pr_ff    <= req_chan.red;
         pg_ff    <= req_chan.green;
         pb_ff    <= req_chan.blue;
         pa_ff    <= req_chan.alpha;
         addr_ff  <= ox_ff;
         first_ff <= row_start & col_start;
         emit_ff  <= row_end & col_end;
         fend_ff  <= last_col & last_row;
      end
      if (state_ff == ST_READ) begin
         acc_ff <= acc_new;
         qr_ff  <= '0;
         qg_ff  <= '0;
         qb_ff  <= '0;
         qa_ff  <= '0;
      end
      if (state_ff == ST_DIV && div_done) begin
         case (sel_ff)
            SEL_RED:   qr_ff <= div_q;
            SEL_GREEN: qg_ff <= div_q;
            SEL_BLUE:  qb_ff <= div_q;
            default:   qa_ff <= div_q;
         endcase
      end
      if (state_ff == ST_OUT && out_free) begin
         o_r_ff  <= qr_ff;
         o_g_ff  <= qg_ff;
         o_b_ff  <= qb_ff;
         o_a_ff  <= qa_ff;
         o_fe_ff <= fend_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_red   = o_r_ff;
   assign rsp_chan.out_green = o_g_ff;
   assign rsp_chan.out_blue  = o_b_ff;
   assign rsp_chan.out_alpha = o_a_ff;
   assign rsp_chan.frame_end = o_fe_ff;
endmodule
`default_nettype wire

// ----- tb/alpha_weighted_box_downscale_tb.sv -----
// Testbench for the alpha weighted box downscaler: directed pixels, then random
// frames under several size settings, checked against a cycle-free pixel model.
// Depends on awbd_pkg, the channel interfaces and the block itself.
`timescale 1ns / 1ps
module alpha_weighted_box_downscale_tb;
   import awbd_pkg::*;

   typedef struct {
      logic [PIX_W-1:0] red, green, blue, alpha;
   } pixel_type;

   typedef struct {
      logic [PIX_W-1:0] red, green, blue, alpha;
      logic             frame_end;
   } block_px_type;

   typedef struct {
      pixel_type    px;
      bit           typed;
      block_px_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   awbd_req_if req_if ();
   awbd_rsp_if rsp_if ();

   alpha_weighted_box_downscale u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if.sink),
      .rsp_chan  (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // model state: column accumulators, position counters, registers
   bit [SUM_W-1:0] acc_red [MAX_WIDTH];
   bit [SUM_W-1:0] acc_green [MAX_WIDTH];
   bit [SUM_W-1:0] acc_blue [MAX_WIDTH];
   bit [SUM_W-1:0] acc_alpha [MAX_WIDTH];
   bit [CNT_W-1:0] acc_count [MAX_WIDTH];
   int unsigned src_col, src_row, out_col, out_row;
   logic [SW_W-1:0] reg_src_w, reg_dst_w;
   logic [SH_W-1:0] reg_src_h, reg_dst_h;

   block_px_type expected_px[$];
   int  errors = 0;
   int  items_sent = 0;
   int  gap_pct = 0;
   int  stall_pct = 0;
   longint cycles = 0;

   function automatic int unsigned clamp_sz(int unsigned v, int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
   endfunction

   function automatic int unsigned edge_of(int unsigned idx, int unsigned src,
                                           int unsigned dst);
      return int'((longint'(idx) * src) / dst);
   endfunction

   function automatic int unsigned weigh(logic [PIX_W-1:0] c, logic [PIX_W-1:0] a);
      return (int'(c) * int'(a)) / 255;
   endfunction

   function automatic void restart_frame();
      src_col = 0; src_row = 0; out_col = 0; out_row = 0;
   endfunction

   // one accepted pixel: update accumulators, maybe produce an output pixel
   function automatic bit downscale_pixel(pixel_type p, output block_px_type o);
      int unsigned sw, sh, tw, th, ox;
      bit rs, cs, ce, re, emits;
      longint a_sum, cnt;
      sw = clamp_sz(reg_src_w, MAX_WIDTH);
      sh = clamp_sz(reg_src_h, MAX_HEIGHT);
      tw = clamp_sz(reg_dst_w, sw);
      th = clamp_sz(reg_dst_h, sh);
      emits = 1'b0;
      o = '{default: '0};
      if (src_col >= sw || src_row >= sh || out_col >= tw || out_row >= th)
         restart_frame();
      ox = out_col;
      rs = (src_row == edge_of(out_row, sh, th));
      cs = (src_col == edge_of(ox, sw, tw));
      ce = (src_col + 1 == edge_of(ox + 1, sw, tw));
      re = (src_row + 1 == edge_of(out_row + 1, sh, th));
      if (rs && cs) begin
         acc_red[ox]   = weigh(p.red, p.alpha);
         acc_green[ox] = weigh(p.green, p.alpha);
         acc_blue[ox]  = weigh(p.blue, p.alpha);
         acc_alpha[ox] = p.alpha;
         acc_count[ox] = 1;
      end else begin
         acc_red[ox]   += weigh(p.red, p.alpha);
         acc_green[ox] += weigh(p.green, p.alpha);
         acc_blue[ox]  += weigh(p.blue, p.alpha);
         acc_alpha[ox] += p.alpha;
         acc_count[ox] += 1;
      end
      if (ce && re) begin
         a_sum = acc_alpha[ox];
         cnt   = acc_count[ox];
         // a fully transparent block leaves all four channels at zero
         if (a_sum != 0 && cnt != 0) begin
            o.red   = PIX_W'((longint'(acc_red[ox]) * 255) / a_sum);
            o.green = PIX_W'((longint'(acc_green[ox]) * 255) / a_sum);
            o.blue  = PIX_W'((longint'(acc_blue[ox]) * 255) / a_sum);
            o.alpha = PIX_W'(a_sum / cnt);
         end
         o.frame_end = (src_col + 1 == sw && src_row + 1 == sh);
         emits = 1'b1;
      end
      if (ce) out_col++;
      src_col++;
      if (src_col >= sw) begin
         src_col = 0;
         out_col = 0;
         if (re) out_row++;
         src_row++;
         if (src_row >= sh) restart_frame();
      end
      return emits;
   endfunction

   // drive one pixel, with random idle cycles ahead of it
   task automatic send_pixel(pixel_type p, bit typed, block_px_type want);
      block_px_type got;
      while ($urandom_range(99) < gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.red   <= p.red;
      req_if.green <= p.green;
      req_if.blue  <= p.blue;
      req_if.alpha <= p.alpha;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (downscale_pixel(p, got))
         expected_px.push_back(typed ? want : got);
      items_sent++;
      if (items_sent > 430) begin
         gap_pct = 0; stall_pct = 0;
      end else if (items_sent > 215) begin
         gap_pct = 84; stall_pct = 6;
      end
   endtask

   // all four registers, only once the block has gone quiet
   task automatic set_sizes(logic [CSR_DATA_W-1:0] sw, logic [CSR_DATA_W-1:0] sh,
                            logic [CSR_DATA_W-1:0] tw, logic [CSR_DATA_W-1:0] th);
      req_if.valid <= 1'b0;
      while (expected_px.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_SRC_WIDTH;  csr_wdata <= sw; @(posedge clock);
      csr_index <= CSR_SRC_HEIGHT; csr_wdata <= sh; @(posedge clock);
      csr_index <= CSR_DST_WIDTH;  csr_wdata <= tw; @(posedge clock);
      csr_index <= CSR_DST_HEIGHT; csr_wdata <= th; @(posedge clock);
      csr_we <= 1'b0;
      reg_src_w = SW_W'(sw);
      reg_src_h = SH_W'(sh);
      reg_dst_w = SW_W'(tw);
      reg_dst_h = SH_W'(th);
      restart_frame();
   endtask

   function automatic pixel_type rand_pixel(int clear_pct);
      pixel_type p;
      int pick;
      p.red   = PIX_W'($urandom);
      p.green = PIX_W'($urandom);
      p.blue  = PIX_W'($urandom);
      pick = $urandom_range(99);
      if (pick < clear_pct) p.alpha = 0;
      else if (pick < clear_pct + 25) p.alpha = 8'hFF;
      else p.alpha = PIX_W'($urandom);
      return p;
   endfunction

   // output side: random stalls and the comparison against the oldest expectation
   always @(posedge clock) begin
      block_px_type w;
      cycles <= cycles + 1;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_px.size() == 0) begin
               $error("output pixel with nothing expected");
               errors++;
            end else begin
               w = expected_px.pop_front();
               if (rsp_if.out_red !== w.red) begin
                  $error("out_red expected %0d got %0d", w.red, rsp_if.out_red);
                  errors++;
               end
               if (rsp_if.out_green !== w.green) begin
                  $error("out_green expected %0d got %0d", w.green, rsp_if.out_green);
                  errors++;
               end
               if (rsp_if.out_blue !== w.blue) begin
                  $error("out_blue expected %0d got %0d", w.blue, rsp_if.out_blue);
                  errors++;
               end
               if (rsp_if.out_alpha !== w.alpha) begin
                  $error("out_alpha expected %0d got %0d", w.alpha, rsp_if.out_alpha);
                  errors++;
               end
               if (rsp_if.frame_end !== w.frame_end) begin
                  $error("frame_end expected %0d got %0d", w.frame_end,
                         rsp_if.frame_end);
                  errors++;
               end
            end
         end
      end
      if (cycles > 3000000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      dir_row_type  table_rows[$];
      block_px_type none;
      pixel_type    p;
      int sw, sh, tw, th, n, clear_pct;
      req_if.valid = 1'b0;
      req_if.red = '0; req_if.green = '0; req_if.blue = '0; req_if.alpha = '0;
      none = '{default: '0};
      reg_src_w = SRC_WIDTH_RST;
      reg_src_h = SRC_HEIGHT_RST;
      reg_dst_w = DST_WIDTH_RST;
      reg_dst_h = DST_HEIGHT_RST;
      restart_frame();
      gap_pct = 6; stall_pct = 84;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset sizes: these pixels, all in the first row, close no block yet
      for (int i = 0; i < 12; i++) send_pixel(rand_pixel(20), 1'b0, none);

      // one-to-one with zero sizes: every pixel is a block and ends the frame
      set_sizes(0, 0, 0, 0);
      table_rows = '{
         '{'{8'hFF, 8'h00, 8'h80, 8'hFF}, 1'b1, '{8'hFF, 8'h00, 8'h80, 8'hFF, 1'b1}},
         '{'{8'h00, 8'h00, 8'h00, 8'hFF}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'hFF, 1'b1}},
         '{'{8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1}},
         '{'{8'hFF, 8'hFF, 8'hFF, 8'h00}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}},
         '{'{8'h5A, 8'hA5, 8'h3C, 8'h00}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}},
         '{'{8'hFF, 8'h01, 8'h80, 8'h80}, 1'b0, none},
         '{'{8'hC3, 8'h3C, 8'h7E, 8'h01}, 1'b0, none},
         '{'{8'h01, 8'hFE, 8'h55, 8'hFE}, 1'b0, none}
      };
      foreach (table_rows[i])
         send_pixel(table_rows[i].px, table_rows[i].typed, table_rows[i].want);

      // 2x2 boxes over a 4x2 image, fully transparent block included
      set_sizes(4, 2, 2, 1);
      for (int i = 0; i < 8; i++) begin
         p = rand_pixel(0);
         if (i == 2 || i == 3 || i == 6 || i == 7) p.alpha = 0;
         send_pixel(p, 1'b0, none);
      end

      // oversized registers clamp to the maxima; target above source clamps
      set_sizes(13'h0FFF, 13'h1FFF, 13'h0FFF, 13'h1FFF);
      for (int i = 0; i < 8; i++) send_pixel(rand_pixel(10), 1'b0, none);
      set_sizes(3, 13'h1FFF, 1, 13'h1FFF);
      for (int i = 0; i < 9; i++) send_pixel(rand_pixel(10), 1'b0, none);

      // random frames, all of small sizes, now and then a clamped target
      while (items_sent < 620) begin
         sw = $urandom_range(12, 1);
         sh = $urandom_range(8, 1);
         tw = ($urandom_range(9) == 0) ? $urandom_range(sw + 3, 0) : $urandom_range(sw, 1);
         th = ($urandom_range(9) == 0) ? $urandom_range(sh + 3, 0) : $urandom_range(sh, 1);
         clear_pct = ($urandom_range(3) == 0) ? 70 : 15;
         set_sizes(CSR_DATA_W'(sw), CSR_DATA_W'(sh), CSR_DATA_W'(tw), CSR_DATA_W'(th));
         n = sw * sh * $urandom_range(2, 1) + $urandom_range(sw);
         for (int i = 0; i < n; i++) send_pixel(rand_pixel(clear_pct), 1'b0, none);
      end

      req_if.valid <= 1'b0;
      while (expected_px.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0 && expected_px.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/core/awbd_pkg.sv
rtl/core/awbd_chan_if.sv
rtl/core/awbd_ram.sv
rtl/core/awbd_div.sv
rtl/core/alpha_weighted_box_downscale.sv
tb/alpha_weighted_box_downscale_tb.sv
